>>> sv/sbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types and constants for the strain bridge conditioner.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int SUM_BITS_DEF    = 28;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 16;
  localparam int QUOT_W    = 32;
  localparam int GAUGE_W   = 32;
  localparam int STRAIN_W  = 32;

  // r3 * 1000 fits in 26 bits; 1e9 fits in 30 bits
  localparam int MILLI         = 1000;
  localparam int A_W           = 26;
  localparam int STRAIN_SCALE  = 1000000000;
  localparam int SCALE_W       = 30;

  localparam int JOB_FIFO_DEPTH = 2;

  localparam logic [CFG_W-1:0] ARM_A_RST        = 16'd350;
  localparam logic [CFG_W-1:0] ARM_B_RST        = 16'd350;
  localparam logic [CFG_W-1:0] REF_ARM_RST      = 16'd350;
  localparam logic [CFG_W-1:0] BLOCK_LEN_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] GAUGE_FACTOR_RST = 16'd2155;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ARM_A        = 3'd0,
    CFG_ARM_B        = 3'd1,
    CFG_REF_ARM      = 3'd2,
    CFG_BLOCK_LEN    = 3'd3,
    CFG_GAUGE_FACTOR = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] arm_a;
    logic [CFG_W-1:0] arm_b;
    logic [CFG_W-1:0] ref_arm;
    logic [CFG_W-1:0] block_len;
    logic [CFG_W-1:0] gauge_factor;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic              big;
    logic [QUOT_W-1:0] quotient;
  } div_result_t;

  typedef struct packed {
    logic [GAUGE_W-1:0]         gauge;
    logic signed [STRAIN_W-1:0] strain;
    logic                       is_ref;
    logic                       over;
  } result_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN
  } div_state_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_FC,
    BK_K,
    BK_PROD,
    BK_SOLVE,
    BK_CHECK,
    BK_GLO,
    BK_GHI,
    BK_GSUM,
    BK_GSTART,
    BK_GWAIT,
    BK_REF,
    BK_ABS,
    BK_SMUL,
    BK_SSTART,
    BK_SWAIT,
    BK_OUT
  } back_state_t;

endpackage

>>> sv/sbc_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_job_fifo
// Small register FIFO holding finished block sums for the back end.
// ----------------------------------------------------------------------------
module sbc_job_fifo #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

>>> sv/sbc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_divider
// Restoring divider, one quotient bit per cycle, 32-bit quotient with overflow.
// ----------------------------------------------------------------------------
module sbc_divider #(
  parameter int P_W = 72,
  parameter int D_W = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [P_W-1:0]       dividend,
  input  logic [D_W-1:0]       divisor,
  output sbc_pkg::div_result_t result
);
  import sbc_pkg::*;

  localparam int HI_W   = P_W - QUOT_W;
  localparam int CMP_W  = (HI_W > D_W) ? HI_W : D_W;
  localparam int STEP_W = $clog2(QUOT_W);

  div_state_t        state;
  div_state_t        state_next;
  logic [HI_W-1:0]   hi;
  logic [QUOT_W-1:0] low;
  logic [D_W-1:0]    dvsr;
  logic [D_W-1:0]    rem;
  logic [QUOT_W-1:0] quot;
  logic [STEP_W-1:0] step;
  logic              done;
  logic              big;
  logic              hi_big;
  logic [D_W:0]      trial;
  logic              ge;
  logic              last;

  // quotient reaches 2^32 exactly when the upper part alone covers the divisor
  assign hi_big = CMP_W'(hi) >= CMP_W'(dvsr);
  assign trial  = {rem, low[QUOT_W-1]};
  assign ge     = trial >= {1'b0, dvsr};
  assign last   = (step == STEP_W'(QUOT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          state_next = DV_CHECK;
        end
      end
      DV_CHECK: begin
        state_next = hi_big ? DV_IDLE : DV_RUN;
      end
      DV_RUN: begin
        if (last) begin
          state_next = DV_IDLE;
        end
      end
      default: state_next = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      big  <= 1'b0;
    end else begin
      done <= ((state == DV_CHECK) && hi_big) || ((state == DV_RUN) && last);
      if (state == DV_CHECK) begin
        big <= hi_big;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: begin
        if (start) begin
          hi   <= dividend[P_W-1:QUOT_W];
          low  <= dividend[QUOT_W-1:0];
          dvsr <= divisor;
        end
        step <= '0;
      end
      DV_CHECK: begin
        rem  <= D_W'(hi);
        quot <= '0;
      end
      DV_RUN: begin
        rem  <= ge ? D_W'(trial - {1'b0, dvsr}) : D_W'(trial);
        low  <= {low[QUOT_W-2:0], 1'b0};
        quot <= {quot[QUOT_W-2:0], ge};
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  assign result.done     = done;
  assign result.big      = big;
  assign result.quotient = quot;
endmodule

>>> sv/sbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_front
// Accepts samples, builds the block sum and hands finished blocks to the queue.
// ----------------------------------------------------------------------------
module sbc_front #(
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_BITS    = 28
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic [sbc_pkg::CFG_W-1:0]  block_len,
  input  logic                       q_full,
  output logic                       full,
  output logic                       q_push,
  output logic [SUM_BITS-1:0]        q_sum,
  output logic [sbc_pkg::CNT_W-1:0]  q_cnt
);
  import sbc_pkg::*;

  logic [SUM_BITS-1:0] sample_sum;
  logic [CNT_W-1:0]    sample_count;
  logic [SUM_BITS-1:0] sum_next;
  logic [CNT_W-1:0]    count_next;
  logic [CFG_W-1:0]    limit;
  logic                accept;
  logic                block_end;

  assign full       = q_full;
  assign accept     = push && !q_full;
  assign sum_next   = sample_sum + SUM_BITS'(sample);
  assign count_next = sample_count + 1'b1;
  // zero length behaves as one sample per block
  assign limit      = (block_len == '0) ? CFG_W'(1) : block_len;
  assign block_end  = (count_next >= limit);

  assign q_push = accept && block_end;
  assign q_sum  = sum_next;
  assign q_cnt  = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (block_end) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= count_next;
      end
    end
  end
endmodule

>>> sv/sbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_back
// Sequencer that solves the bridge and the strain for one block sum.
// ----------------------------------------------------------------------------
module sbc_back #(
  parameter int SAMPLE_BITS = 12,
  parameter int SUM_BITS    = 28
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sbc_pkg::cfg_t             cfg,
  input  logic                      job_valid,
  input  logic [SUM_BITS-1:0]       job_sum,
  input  logic [sbc_pkg::CNT_W-1:0] job_cnt,
  output logic                      job_pop,
  input  logic                      res_ready,
  output logic                      res_valid,
  output sbc_pkg::result_t          res
);
  import sbc_pkg::*;

  localparam int FC_W   = SAMPLE_BITS + CNT_W;
  localparam int DS_W   = FC_W + 1;
  localparam int K_W    = ((SUM_BITS + 1 > FC_W) ? SUM_BITS + 1 : FC_W) + 1;
  localparam int SR_W   = CFG_W + 1;
  localparam int PAB_W  = CFG_W + DS_W;
  localparam int PS_W   = SR_W + 1 + K_W;
  localparam int NUM_W  = ((PAB_W + 1 > PS_W) ? PAB_W + 1 : PS_W) + 1;
  localparam int NMAG_W = NUM_W - 1;
  localparam int NHI_W  = NMAG_W - QUOT_W;
  localparam int PLO_W  = A_W + QUOT_W;
  localparam int PHI_W  = A_W + NHI_W;
  localparam int PG_W   = A_W + NMAG_W;
  localparam int MAG_W  = GAUGE_W + SCALE_W;
  localparam int SDEN_W = CFG_W + GAUGE_W;
  localparam int P_W    = (PG_W > MAG_W) ? PG_W : MAG_W;
  localparam int D_W    = (NMAG_W > SDEN_W) ? NMAG_W : SDEN_W;
  localparam int DIFF_W = GAUGE_W + 1;

  localparam logic [SAMPLE_BITS-1:0]     FULL_SCALE = '1;
  localparam logic [GAUGE_W-1:0]         GAUGE_MAX  = '1;
  localparam logic signed [STRAIN_W-1:0] STRAIN_MAX = {1'b0, {(STRAIN_W-1){1'b1}}};
  localparam logic signed [STRAIN_W-1:0] STRAIN_MIN = {1'b1, {(STRAIN_W-1){1'b0}}};

  back_state_t              state;
  back_state_t              state_next;
  logic                     div_start;
  logic [D_W-1:0]           div_divisor;
  div_result_t              div_res;

  logic [SUM_BITS-1:0]      sum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [FC_W-1:0]          fc;
  logic [SR_W-1:0]          sr;
  logic [A_W-1:0]           amul;
  logic signed [K_W-1:0]    k;
  logic [PAB_W-1:0]         pa;
  logic [PAB_W-1:0]         pb;
  logic signed [PS_W-1:0]   ps;
  logic signed [NUM_W-1:0]  num;
  logic signed [NUM_W-1:0]  den;
  logic [PLO_W-1:0]         plo;
  logic [PHI_W-1:0]         phi;
  logic [P_W-1:0]           prod_p;
  logic [GAUGE_W-1:0]       gauge;
  logic                     over;
  logic                     is_ref;
  logic [GAUGE_W-1:0]       ref_mohm;
  logic                     ref_valid;
  logic signed [DIFF_W-1:0] diff;
  logic [GAUGE_W-1:0]       absd;
  logic [SDEN_W-1:0]        sden;
  logic signed [STRAIN_W-1:0] strain;

  logic [DS_W-1:0]          ds;
  logic                     den_bad;
  logic [GAUGE_W-1:0]       ref_use;
  logic                     neg_over;
  logic                     pos_over;

  assign ds       = {fc, 1'b0};
  assign den_bad  = den[NUM_W-1] || (den == '0);
  assign ref_use  = ref_valid ? ref_mohm : gauge;
  assign pos_over = div_res.big || div_res.quotient[QUOT_W-1];
  assign neg_over = div_res.big ||
                    (div_res.quotient[QUOT_W-1] && (div_res.quotient[QUOT_W-2:0] != '0));

  assign div_divisor = (state == BK_GSTART) ? D_W'(den[NMAG_W-1:0]) : D_W'(sden);

  sbc_divider #(
    .P_W (P_W),
    .D_W (D_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_p),
    .divisor  (div_divisor),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    div_start  = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          state_next = BK_FC;
        end
      end
      BK_FC:    state_next = BK_K;
      BK_K:     state_next = BK_PROD;
      BK_PROD:  state_next = BK_SOLVE;
      BK_SOLVE: state_next = BK_CHECK;
      BK_CHECK: begin
        state_next = (den_bad || num[NUM_W-1]) ? BK_REF : BK_GLO;
      end
      BK_GLO:   state_next = BK_GHI;
      BK_GHI:   state_next = BK_GSUM;
      BK_GSUM:  state_next = BK_GSTART;
      BK_GSTART: begin
        div_start  = 1'b1;
        state_next = BK_GWAIT;
      end
      BK_GWAIT: begin
        if (div_res.done) begin
          state_next = BK_REF;
        end
      end
      BK_REF:   state_next = BK_ABS;
      BK_ABS:   state_next = BK_SMUL;
      BK_SMUL:  state_next = BK_SSTART;
      BK_SSTART: begin
        if (sden == '0) begin
          state_next = BK_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = BK_SWAIT;
        end
      end
      BK_SWAIT: begin
        if (div_res.done) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // reference resistance, captured by the first block after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_valid <= 1'b0;
      ref_mohm  <= '0;
    end else if ((state == BK_REF) && !ref_valid) begin
      ref_valid <= 1'b1;
      ref_mohm  <= gauge;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        sum_r  <= job_sum;
        cnt_r  <= job_cnt;
        over   <= 1'b0;
        is_ref <= 1'b0;
      end
      BK_FC: begin
        fc   <= FC_W'(FULL_SCALE) * FC_W'(cnt_r);
        sr   <= SR_W'(cfg.arm_a) + SR_W'(cfg.arm_b);
        amul <= A_W'(cfg.ref_arm) * A_W'(MILLI);
      end
      BK_K: begin
        k <= $signed(K_W'(fc)) - $signed(K_W'({sum_r, 1'b0}));
      end
      BK_PROD: begin
        pa <= PAB_W'(cfg.arm_a) * PAB_W'(ds);
        pb <= PAB_W'(cfg.arm_b) * PAB_W'(ds);
        ps <= PS_W'($signed({1'b0, sr})) * PS_W'(k);
      end
      BK_SOLVE: begin
        num <= NUM_W'($signed({1'b0, pb})) - NUM_W'(ps);
        den <= NUM_W'($signed({1'b0, pa})) + NUM_W'(ps);
      end
      BK_CHECK: begin
        if (den_bad) begin
          gauge <= GAUGE_MAX;
          over  <= 1'b1;
        end else if (num[NUM_W-1]) begin
          gauge <= '0;
          over  <= 1'b1;
        end
      end
      BK_GLO: begin
        plo <= PLO_W'(amul) * PLO_W'(num[QUOT_W-1:0]);
      end
      BK_GHI: begin
        phi <= PHI_W'(amul) * PHI_W'(num[NMAG_W-1:QUOT_W]);
      end
      BK_GSUM: begin
        prod_p <= (P_W'(phi) << QUOT_W) + P_W'(plo);
      end
      BK_GWAIT: begin
        if (div_res.done) begin
          if (div_res.big) begin
            gauge <= GAUGE_MAX;
            over  <= 1'b1;
          end else begin
            gauge <= div_res.quotient;
          end
        end
      end
      BK_REF: begin
        diff <= $signed({1'b0, ref_use}) - $signed({1'b0, gauge});
        if (!ref_valid) begin
          is_ref <= 1'b1;
        end
      end
      BK_ABS: begin
        absd <= diff[DIFF_W-1] ? GAUGE_W'(-diff) : diff[GAUGE_W-1:0];
      end
      BK_SMUL: begin
        prod_p <= P_W'(MAG_W'(absd) * MAG_W'(STRAIN_SCALE));
        sden   <= SDEN_W'(cfg.gauge_factor) * SDEN_W'(ref_mohm);
      end
      BK_SSTART: begin
        if (sden == '0) begin
          over <= 1'b1;
          if (diff[DIFF_W-1]) begin
            strain <= STRAIN_MIN;
          end else if (diff != '0) begin
            strain <= STRAIN_MAX;
          end else begin
            strain <= '0;
          end
        end
      end
      BK_SWAIT: begin
        if (div_res.done) begin
          if (diff[DIFF_W-1]) begin
            strain <= neg_over ? STRAIN_MIN : -$signed(div_res.quotient);
            if (neg_over) begin
              over <= 1'b1;
            end
          end else begin
            strain <= pos_over ? STRAIN_MAX : $signed(div_res.quotient);
            if (pos_over) begin
              over <= 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign res.gauge  = gauge;
  assign res.strain = strain;
  assign res.is_ref = is_ref;
  assign res.over   = over;
endmodule

>>> sv/strain_bridge_conditioner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strain_bridge_conditioner
// Quarter-bridge strain gauge conditioner: block average, bridge solve, strain.
// ----------------------------------------------------------------------------
// A sample that closes a block shows its result after the back-end sequencing
//   and up to two passes of the shared bit-serial divider (resistance, then
//   strain); the back end works on one block end at a time.
// Throughput: one sample per cycle inside a block while the job queue is
//   not full; two block ends wait between the accumulator and the sequencer.
// Reset (rst, synchronous): clears sum, count, reference, queues, sequencer.
module strain_bridge_conditioner #(
  parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_BITS    = sbc_pkg::SUM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample request side
  input  logic                          push,
  output logic                          full,
  input  logic [SAMPLE_BITS-1:0]        adc_sample,
  // result request side
  output logic                          empty,
  input  logic                          pop,
  output logic [sbc_pkg::GAUGE_W-1:0]   gauge_milliohms,
  output logic signed [sbc_pkg::STRAIN_W-1:0] microstrain,
  output logic                          is_reference,
  output logic                          overrange,
  // register write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbc_pkg::CFG_W-1:0]     cfg_data
);
  import sbc_pkg::*;

  localparam int JOB_W = SUM_BITS + CNT_W;

  cfg_t                cfg;
  logic                job_push;
  logic                job_full;
  logic                job_empty;
  logic                job_pop;
  logic [SUM_BITS-1:0] job_sum_in;
  logic [CNT_W-1:0]    job_cnt_in;
  logic [JOB_W-1:0]    job_rd;
  logic                res_valid;
  logic                res_ready;
  result_t             res;
  logic                out_valid;

  // --------------------------------------------------------------------------
  // Configuration registers. The write channel never stalls; indexes past
  // the register list are dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_a        <= ARM_A_RST;
      cfg.arm_b        <= ARM_B_RST;
      cfg.ref_arm      <= REF_ARM_RST;
      cfg.block_len    <= BLOCK_LEN_RST;
      cfg.gauge_factor <= GAUGE_FACTOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ARM_A:        cfg.arm_a        <= cfg_data;
        CFG_ARM_B:        cfg.arm_b        <= cfg_data;
        CFG_REF_ARM:      cfg.ref_arm      <= cfg_data;
        CFG_BLOCK_LEN:    cfg.block_len    <= cfg_data;
        CFG_GAUGE_FACTOR: cfg.gauge_factor <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front end: running sum, pushes the (sum, count) pair at each block end.
  // It stalls only when the job queue is full.
  // --------------------------------------------------------------------------
  sbc_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (adc_sample),
    .block_len (cfg.block_len),
    .q_full    (job_full),
    .full      (full),
    .q_push    (job_push),
    .q_sum     (job_sum_in),
    .q_cnt     (job_cnt_in)
  );

  // Decouples the sample stream from the long back-end computation.
  sbc_job_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_FIFO_DEPTH)
  ) u_jobs (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wr_data ({job_sum_in, job_cnt_in}),
    .pop     (job_pop),
    .full    (job_full),
    .empty   (job_empty),
    .rd_data (job_rd)
  );

  // --------------------------------------------------------------------------
  // Back end: bridge solve, reference capture and strain, one job at a time.
  // --------------------------------------------------------------------------
  sbc_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!job_empty),
    .job_sum   (job_rd[JOB_W-1:CNT_W]),
    .job_cnt   (job_rd[CNT_W-1:0]),
    .job_pop   (job_pop),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // --------------------------------------------------------------------------
  // Output register. Refills in the same cycle the held result is popped.
  // --------------------------------------------------------------------------
  assign res_ready = !out_valid || pop;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      gauge_milliohms <= res.gauge;
      microstrain     <= res.strain;
      is_reference    <= res.is_ref;
      overrange       <= res.over;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("block end pushed into a full job queue");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> !empty)
    else $error("accepted result not shown at the output");

  a_reference_zero_strain: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_reference) |-> (microstrain == '0))
    else $error("reference block reports nonzero strain");

endmodule
